### hw/rtl/iklpm_pkg.sv
// Shared types, codes and defaults for the integer-key linear-probe map.
package iklpm_pkg;

    localparam int SLOTS_DEF      = 1024;
    localparam int VALUE_BITS_DEF = 32;
    localparam int KEY_W          = 32;
    localparam int VAL_W          = 32;

    // operation codes
    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_GET    = 2'd1;
    localparam logic [1:0] KIND_REMOVE = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NULL      = 2'd3;

    typedef struct packed {
        logic [1:0]              kind;
        logic signed [KEY_W-1:0] key;
        logic [VAL_W-1:0]        value;
    } t_in;

    typedef struct packed {
        logic [1:0]       status;
        logic [VAL_W-1:0] value_out;
    } t_out;

    // controller -> datapath
    typedef struct packed {
        logic       clr_step;
        logic       load_item;
        logic       rd;
        logic       probe_next;
        logic       write_ins;
        logic       write_rem;
        logic       set_res;
        logic       take_value;
        logic [1:0] res_status;
        logic       push;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic       clr_done;
        logic       quick;
        logic [1:0] quick_status;
        logic       hit;
        logic       last;
        logic [1:0] kind;
    } t_sts;

endpackage

### hw/rtl/iklpm_ram.sv
// Generic simple dual-port RAM with registered read.
module iklpm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/iklpm_ctrl.sv
// Sequencer: clearing pass, item intake, probe loop and result hand-off.
module iklpm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  iklpm_pkg::t_sts   i_sts,
    output iklpm_pkg::t_cmd   o_cmd
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]      r_state, n_state;
    logic            r_out_valid;
    iklpm_pkg::t_cmd cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load_item = 1'b1;
                    if (i_sts.quick) begin
                        cmd.set_res    = 1'b1;
                        cmd.res_status = i_sts.quick_status;
                        n_state        = S_DONE;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                cmd.rd  = 1'b1;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_sts.hit) begin
                    cmd.set_res    = 1'b1;
                    cmd.res_status = iklpm_pkg::ST_OK;
                    cmd.write_ins  = (i_sts.kind == iklpm_pkg::KIND_INSERT);
                    cmd.take_value = (i_sts.kind == iklpm_pkg::KIND_GET);
                    cmd.write_rem  = (i_sts.kind == iklpm_pkg::KIND_REMOVE);
                    n_state        = S_DONE;
                end else if (i_sts.last) begin
                    cmd.set_res    = 1'b1;
                    cmd.res_status = iklpm_pkg::ST_NOT_FOUND;
                    n_state        = S_DONE;
                end else begin
                    cmd.probe_next = 1'b1;
                    n_state        = S_READ;
                end
            end
            S_DONE: begin
                // output register free, or its beat is taken this cycle
                if (!r_out_valid || !i_out_stall) begin
                    cmd.push = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

### hw/rtl/iklpm_dp.sv
// Datapath: item registers, probe pointer, slot stores, entry count, result.
module iklpm_dp #(
    parameter int SLOTS      = iklpm_pkg::SLOTS_DEF,
    parameter int VALUE_BITS = iklpm_pkg::VALUE_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  iklpm_pkg::t_in    i_in_data,
    input  iklpm_pkg::t_cmd   i_cmd,
    output iklpm_pkg::t_sts   o_sts,
    output iklpm_pkg::t_out   o_out_data
);

    localparam int AW    = $clog2(SLOTS);
    localparam int CNT_W = AW + 1;
    localparam int KW    = iklpm_pkg::KEY_W;
    localparam int VW    = iklpm_pkg::VAL_W;
    localparam logic [CNT_W-1:0] HALF = CNT_W'(SLOTS / 2);

    logic [1:0]            r_kind;
    logic [KW-1:0]         r_key;
    logic [VALUE_BITS-1:0] r_value;
    logic [AW-1:0]         r_addr;
    logic [AW-1:0]         r_n;
    logic [CNT_W-1:0]      r_count;
    logic [AW-1:0]         r_clr;
    logic [1:0]            r_res_status;
    logic [VW-1:0]         r_res_value;
    iklpm_pkg::t_out       r_out;

    logic [VALUE_BITS-1:0] in_val;
    logic                  vld_rd;
    logic [KW+VALUE_BITS-1:0] slot_rd;
    logic [KW-1:0]         key_rd;
    logic [VALUE_BITS-1:0] val_rd;
    logic                  vld_we;
    logic [AW-1:0]         vld_waddr;

    assign in_val = VALUE_BITS'(i_in_data.value);
    assign key_rd = slot_rd[KW+VALUE_BITS-1:VALUE_BITS];
    assign val_rd = slot_rd[VALUE_BITS-1:0];

    // valid bits are cleared by the reset pass; key/value words never are
    assign vld_we    = i_cmd.clr_step | i_cmd.write_ins | i_cmd.write_rem;
    assign vld_waddr = i_cmd.clr_step ? r_clr : r_addr;

    iklpm_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_valid (
        .i_clk   (i_clk),
        .i_we    (vld_we),
        .i_waddr (vld_waddr),
        .i_wdata (i_cmd.write_ins),
        .i_re    (i_cmd.rd),
        .i_raddr (r_addr),
        .o_rdata (vld_rd)
    );

    iklpm_ram #(.WIDTH(KW + VALUE_BITS), .DEPTH(SLOTS)) u_slot (
        .i_clk   (i_clk),
        .i_we    (i_cmd.write_ins),
        .i_waddr (r_addr),
        .i_wdata ({r_key, r_value}),
        .i_re    (i_cmd.rd),
        .i_raddr (r_addr),
        .o_rdata (slot_rd)
    );

    always_comb begin
        o_sts.clr_done     = (r_clr == {AW{1'b1}});
        o_sts.quick        = 1'b0;
        o_sts.quick_status = iklpm_pkg::ST_OK;
        if (i_in_data.kind == iklpm_pkg::KIND_INSERT) begin
            if (in_val == '0) begin
                o_sts.quick        = 1'b1;
                o_sts.quick_status = iklpm_pkg::ST_NULL;
            end else if (r_count >= HALF) begin
                o_sts.quick        = 1'b1;
                o_sts.quick_status = iklpm_pkg::ST_FULL;
            end
        end else if (i_in_data.kind == iklpm_pkg::KIND_NONE) begin
            o_sts.quick = 1'b1;
        end
        // insert looks for a free slot, get/remove for a live matching key
        if (r_kind == iklpm_pkg::KIND_INSERT) begin
            o_sts.hit = !vld_rd;
        end else begin
            o_sts.hit = vld_rd && (key_rd == r_key);
        end
        o_sts.last = (r_n == {AW{1'b1}});
        o_sts.kind = r_kind;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_clr   <= '0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr <= r_clr + AW'(1);
            end
            if (i_cmd.write_ins) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.write_rem) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_kind  <= i_in_data.kind;
            r_key   <= $unsigned(i_in_data.key);
            r_value <= in_val;
            r_addr  <= i_in_data.key[AW-1:0];
            r_n     <= '0;
        end else if (i_cmd.probe_next) begin
            r_addr <= r_addr + AW'(1);
            r_n    <= r_n + AW'(1);
        end
        if (i_cmd.set_res) begin
            r_res_status <= i_cmd.res_status;
            r_res_value  <= i_cmd.take_value ? VW'(val_rd) : '0;
        end
        if (i_cmd.push) begin
            r_out.status    <= r_res_status;
            r_out.value_out <= r_res_value;
        end
    end

    assign o_out_data = r_out;

endmodule

### hw/rtl/int_key_linear_probe_map.sv
// Top level of the integer-key linear-probe map.
// Open-addressing map of SLOTS slots (power of two) from 32-bit signed keys
// to VALUE_BITS-bit values. After reset a clearing pass over all SLOTS
// slots wipes the valid bits; no item is accepted until it ends. One item
// is worked at a time: a beat rejected up front (null value, load limit,
// unused kind) goes straight to its result; any other probes the ring from
// its home slot until a hit, or over all SLOTS slots for a get or remove
// miss. Each probed slot passes a read state and a compare state, as the
// slot RAMs have registered read. A finished result waits in an output
// register, so the next item is taken while it is stalled.
module int_key_linear_probe_map #(
    parameter int SLOTS      = iklpm_pkg::SLOTS_DEF,
    parameter int VALUE_BITS = iklpm_pkg::VALUE_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  iklpm_pkg::t_in   i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output iklpm_pkg::t_out  o_out_data
);

    iklpm_pkg::t_cmd cmd;
    iklpm_pkg::t_sts sts;

    iklpm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    iklpm_dp #(.SLOTS(SLOTS), .VALUE_BITS(VALUE_BITS)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out_data (o_out_data)
    );

endmodule

### hw/rtl/iklpm_checker.sv
// Port-level assertions for the linear-probe map, bound to the top level.
module iklpm_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            o_in_stall,
    input logic            o_out_valid,
    input logic            i_out_stall,
    input iklpm_pkg::t_out o_out_data
);

    // one item in flight: an accepted beat closes the input side
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted while an item is in progress");

    a_value_zero_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status != iklpm_pkg::ST_OK))
            |-> (o_out_data.value_out == '0))
        else $error("nonzero value_out with error status");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && o_in_stall))
        else $error("handshake active right after reset");

    a_out_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result beat dropped while stalled");

    a_out_data_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_out_data))
        else $error("result beat changed while stalled");

endmodule

bind int_key_linear_probe_map iklpm_checker u_iklpm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

### tb/int_key_linear_probe_map_tb.sv
// Self-checking testbench for the integer-key linear-probe map.
module int_key_linear_probe_map_tb;
    import iklpm_pkg::*;

    localparam int SLOTS     = SLOTS_DEF;
    localparam int HOME_BITS = $clog2(SLOTS);

    logic i_clk      = 1'b0;
    logic i_rst_n    = 1'b0;
    logic i_in_valid = 1'b0;
    logic i_out_stall = 1'b0;
    t_in  i_in_data  = '0;
    logic o_in_stall;
    logic o_out_valid;
    t_out o_out_data;

    int_key_linear_probe_map #(
        .SLOTS      (SLOTS),
        .VALUE_BITS (VALUE_BITS_DEF)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // mirror of the map contents
    logic [KEY_W-1:0] tbl_key  [SLOTS];
    logic [VAL_W-1:0] tbl_val  [SLOTS];
    bit               tbl_used [SLOTS];
    int               tbl_count = 0;

    t_out             results_due [$];
    t_out             due;
    logic [KEY_W-1:0] key_pool [16];
    bit               steady = 1'b0;
    int               err_count = 0;

    initial forever #6 i_clk = ~i_clk;

    initial begin
        #200_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic report(input string what, input logic [63:0] want_v,
                          input logic [63:0] got_v);
        $display("ERROR at %0t: %s expected %h got %h", $time, what, want_v, got_v);
        err_count++;
    endtask

    // mostly short gaps, a few long ones, none while steady
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int home_of(input logic [KEY_W-1:0] k);
        return int'(k & (SLOTS - 1));
    endfunction

    // first valid slot holding k, scanning the whole ring from home
    function automatic int locate(input logic [KEY_W-1:0] k);
        int slot;
        int found;
        found = -1;
        for (int n = SLOTS - 1; n >= 0; n--) begin
            slot = (home_of(k) + n) % SLOTS;
            if (tbl_used[slot] && tbl_key[slot] == k) found = slot;
        end
        return found;
    endfunction

    task automatic apply_map_op(input t_in d, output t_out r);
        int slot;
        int free_slot;
        r.status    = ST_OK;
        r.value_out = '0;
        case (d.kind)
            KIND_INSERT: begin
                if (d.value == '0) begin
                    r.status = ST_NULL;
                end else if (tbl_count >= SLOTS / 2) begin
                    r.status = ST_FULL;
                end else begin
                    free_slot = -1;
                    for (int n = SLOTS - 1; n >= 0; n--) begin
                        slot = (home_of(d.key) + n) % SLOTS;
                        if (!tbl_used[slot]) free_slot = slot;
                    end
                    tbl_key[free_slot]  = d.key;
                    tbl_val[free_slot]  = d.value;
                    tbl_used[free_slot] = 1'b1;
                    tbl_count++;
                end
            end
            KIND_GET: begin
                slot = locate(d.key);
                if (slot < 0) r.status = ST_NOT_FOUND;
                else r.value_out = tbl_val[slot];
            end
            KIND_REMOVE: begin
                slot = locate(d.key);
                if (slot < 0) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    tbl_used[slot] = 1'b0;
                    tbl_count--;
                end
            end
            default: ;
        endcase
    endtask

    // random key currently in the map, or a random word when the map is empty
    function automatic logic [KEY_W-1:0] stored_key();
        int start;
        int pick;
        pick  = -1;
        start = $urandom_range(0, SLOTS - 1);
        for (int n = SLOTS - 1; n >= 0; n--)
            if (tbl_used[(start + n) % SLOTS]) pick = (start + n) % SLOTS;
        if (pick < 0) return $urandom;
        return tbl_key[pick];
    endfunction

    function automatic logic [KEY_W-1:0] fresh_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) return key_pool[$urandom_range(0, 15)];
        // same home as a pool key, different upper bits
        if (r < 30) return key_pool[$urandom_range(0, 15)] ^ ($urandom << HOME_BITS);
        if (r < 36) begin
            case ($urandom_range(0, 4))
                0: return 32'hFFFF_FFFF;
                1: return 32'h8000_0000;
                2: return 32'h7FFF_FFFF;
                3: return '0;
                default: return SLOTS - 1;
            endcase
        end
        return $urandom;
    endfunction

    function automatic t_in op_item(input logic [1:0] kind, input logic [KEY_W-1:0] k,
                                    input logic [VAL_W-1:0] v);
        t_in d;
        d.kind  = kind;
        d.key   = k;
        d.value = v;
        return d;
    endfunction

    function automatic t_in make_op(input int ins_pct, input int miss_pct);
        t_in d;
        int r;
        r       = $urandom_range(0, 99);
        d.value = $urandom;
        if (r < ins_pct) begin
            d.kind = KIND_INSERT;
            d.key  = fresh_key();
            if ($urandom_range(0, 99) < 3) d.value = '0;
        end else if (r < ins_pct + 3) begin
            d.kind = KIND_NONE;
            d.key  = $urandom;
        end else begin
            d.kind = ($urandom_range(0, 99) < 55) ? KIND_GET : KIND_REMOVE;
            d.key  = ($urandom_range(0, 99) < miss_pct) ? $urandom : stored_key();
        end
        return d;
    endfunction

    // called right after a rising edge; returns at a rising edge
    task automatic send_item(input t_in d);
        t_out r;
        int gap;
        i_in_valid <= 1'b1;
        i_in_data  <= d;
        do @(posedge i_clk); while (o_in_stall);
        apply_map_op(d, r);
        results_due.push_back(r);
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (results_due.size() != 0);
    endtask

    // result side back-pressure
    initial begin
        int n;
        @(posedge i_clk);
        forever begin
            n = pick_gap();
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (results_due.size() == 0) begin
                report("unexpected result beat", '0, o_out_data);
            end else begin
                due = results_due.pop_front();
                if (o_out_data.status !== due.status)
                    report("status", due.status, o_out_data.status);
                if (o_out_data.value_out !== due.value_out)
                    report("value_out", due.value_out, o_out_data.value_out);
            end
        end
    end

    task automatic test_directed();
        send_item(op_item(KIND_GET,    32'd5, '0));           // miss on empty ring
        send_item(op_item(KIND_REMOVE, 32'd5, '0));
        send_item(op_item(KIND_INSERT, 32'd5, '0));           // null value
        send_item(op_item(KIND_NONE,   32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(op_item(KIND_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(op_item(KIND_INSERT, SLOTS - 1, 32'd1));    // wraps to slot 0
        send_item(op_item(KIND_INSERT, 32'd0, 32'h8000_0000));
        send_item(op_item(KIND_INSERT, 32'h8000_0000, 32'h1234_5678));
        send_item(op_item(KIND_INSERT, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_item(op_item(KIND_GET,    32'd0, '0));
        send_item(op_item(KIND_GET,    32'h7FFF_FFFF, '0));
        send_item(op_item(KIND_GET,    32'hFFFF_FFFF, '0));
        send_item(op_item(KIND_INSERT, 32'd5, 32'hAAAA_AAAA));
        send_item(op_item(KIND_INSERT, 32'd5, 32'h5555_5555)); // duplicate key
        send_item(op_item(KIND_GET,    32'd5, '0));
        send_item(op_item(KIND_REMOVE, 32'd5, '0));
        send_item(op_item(KIND_GET,    32'd5, '0));
        send_item(op_item(KIND_REMOVE, 32'hFFFF_FFFF, '0));    // hole at top of ring
        send_item(op_item(KIND_GET,    32'h7FFF_FFFF, '0));    // scan past the hole
        send_item(op_item(KIND_GET,    SLOTS - 1, '0));
        send_item(op_item(KIND_REMOVE, SLOTS, '0));
        send_item(op_item(KIND_GET,    32'h8000_0000, '0));
    endtask

    task automatic test_mixed_growth();
        foreach (key_pool[i]) key_pool[i] = $urandom;
        repeat (300) send_item(make_op(60, 5));
    endtask

    task automatic test_load_limit();
        while (tbl_count < SLOTS / 2)
            send_item(op_item(KIND_INSERT, fresh_key(), $urandom));
        repeat (8) send_item(op_item(KIND_INSERT, fresh_key(), $urandom));
        send_item(op_item(KIND_INSERT, fresh_key(), '0));     // null wins over full
        repeat (6) send_item(op_item(KIND_GET, stored_key(), $urandom));
        send_item(op_item(KIND_REMOVE, stored_key(), $urandom));
        send_item(op_item(KIND_INSERT, fresh_key(), $urandom));
        send_item(op_item(KIND_INSERT, fresh_key(), $urandom));
    endtask

    task automatic test_back_to_back();
        steady = 1'b1;
        repeat (150) send_item(make_op(40, 4));
        steady = 1'b0;
    endtask

    task automatic test_churn();
        repeat (250) send_item(make_op(45, 5));
    endtask

    task automatic test_drain();
        while (tbl_count > 0) begin
            if ($urandom_range(0, 99) < 10)
                send_item(op_item(KIND_GET, stored_key(), $urandom));
            else
                send_item(op_item(KIND_REMOVE, stored_key(), $urandom));
        end
        send_item(op_item(KIND_GET, $urandom, $urandom));
        send_item(op_item(KIND_INSERT, fresh_key(), $urandom));
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_mixed_growth();
        wait_drained();
        test_load_limit();
        test_back_to_back();
        test_churn();
        test_drain();
        wait_drained();
        repeat (2 * SLOTS + 8) @(posedge i_clk);
        if (err_count == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### sim.f
hw/rtl/iklpm_pkg.sv
hw/rtl/iklpm_ram.sv
hw/rtl/iklpm_ctrl.sv
hw/rtl/iklpm_dp.sv
hw/rtl/int_key_linear_probe_map.sv
hw/rtl/iklpm_checker.sv
tb/int_key_linear_probe_map_tb.sv
